// ===== rtl/core/pht_pkg.sv =====
// ============================================================================
// Page hotness tracker package
// Shared widths, record and command types, and the degree and countdown
// helper functions of the page hotness tracker.
// ============================================================================
package pht_pkg;

  // Sizing of the record store and of the per-page state.
  localparam int PAGE_ENTRIES   = 1024;
  localparam int HISTORY_BITS   = 16;
  localparam int DEGREE_BUCKETS = 16;
  localparam int QUEUE_LEVELS   = 4;

  // Port field widths.
  localparam int OPCODE_W   = 2;
  localparam int PAGE_IDX_W = 10;
  localparam int DEGREE_W   = 4;
  localparam int QLEVEL_W   = 2;
  localparam int THR_W      = 4;

  // Internal widths derived from the sizing above.
  localparam int IDX_W   = $clog2(PAGE_ENTRIES);
  localparam int LEVEL_W = $clog2(QUEUE_LEVELS);
  // The longest countdown is 2^(QUEUE_LEVELS-2), set at the top level.
  localparam int DND_W   = QUEUE_LEVELS - 1;
  localparam int DEG_W   = $clog2(DEGREE_BUCKETS);
  localparam int CNT_W   = $clog2(HISTORY_BITS + 1);
  localparam int SUM_W   = $clog2(5 * HISTORY_BITS + 1);

  // Division by five as a multiply by 205/1024, exact for sums below 1024.
  localparam int DIV5_MUL   = 205;
  localparam int DIV5_SHIFT = 10;
  localparam int PROD_W     = SUM_W + 8;

  // Command queue between front and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_TRACK   = 2'd0,
    OP_SCAN    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  // One page record as held in the record store.
  typedef struct packed {
    logic               valid;
    logic               skip;
    logic               huge;
    logic [LEVEL_W-1:0] level;
    logic [DND_W-1:0]   dnd;
    logic [HISTORY_BITS-1:0] rd;
    logic [HISTORY_BITS-1:0] wr;
  } rec_t;

  // Classified command handed from the front end to the back end.
  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] idx;
    logic             huge;
    logic             mapped;
    logic             accessed;
    logic             dirty;
  } cmd_t;

  // Conditions that hold off the front end.
  typedef struct packed {
    logic queue_full;
    logic init_busy;
  } front_stall_t;

  // Hotness degree: min((2*reads + 3*writes) / 5, DEGREE_BUCKETS-1).
  function automatic logic [DEG_W-1:0] deg_of(input logic [HISTORY_BITS-1:0] rd,
                                                input logic [HISTORY_BITS-1:0] wr);
    logic [CNT_W-1:0]  cnt_r;
    logic [CNT_W-1:0]  cnt_w;
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  quo;
    cnt_r = CNT_W'($countones(rd));
    cnt_w = CNT_W'($countones(wr));
    sum   = (SUM_W'(cnt_r) << 1) + SUM_W'(cnt_w) + (SUM_W'(cnt_w) << 1);
    prod  = PROD_W'(sum) * PROD_W'(DIV5_MUL);
    quo   = SUM_W'(prod >> DIV5_SHIFT);
    if (quo > SUM_W'(DEGREE_BUCKETS - 1)) begin
      return DEG_W'(DEGREE_BUCKETS - 1);
    end
    return DEG_W'(quo);
  endfunction

  // Do-not-disturb countdown loaded on entering a level.
  function automatic logic [DND_W-1:0] dnd_for(input logic [LEVEL_W-1:0] lev);
    if (lev == '0) begin
      return '0;
    end
    return DND_W'(1) << (lev - LEVEL_W'(1));
  endfunction

endpackage

// ===== rtl/core/pht_if.sv =====
// ============================================================================
// Page hotness tracker channels
// Valid/ready channels for the operation input and the result output.
// ============================================================================
interface pht_in_if;
  logic                           valid;
  logic                           ready;
  logic [pht_pkg::OPCODE_W-1:0]   opcode;
  logic [pht_pkg::PAGE_IDX_W-1:0] page_index;
  logic                           huge_page;
  logic                           mapped;
  logic                           accessed;
  logic                           dirty;

  modport source (output valid, output opcode, output page_index, output huge_page,
                  output mapped, output accessed, output dirty, input ready);
  modport sink (input valid, input opcode, input page_index, input huge_page,
                input mapped, input accessed, input dirty, output ready);
endinterface

interface pht_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [pht_pkg::DEGREE_W-1:0] degree;
  logic                         degree_changed;
  logic                         is_hot;
  logic                         clear_accessed;
  logic                         clear_dirty;
  logic                         flush_range;
  logic                         is_huge;
  logic [pht_pkg::QLEVEL_W-1:0] queue_level;

  modport source (output valid, output found, output degree, output degree_changed,
                  output is_hot, output clear_accessed, output clear_dirty,
                  output flush_range, output is_huge, output queue_level, input ready);
  modport sink (input valid, input found, input degree, input degree_changed,
                input is_hot, input clear_accessed, input clear_dirty,
                input flush_range, input is_huge, input queue_level, output ready);
endinterface

// ===== rtl/core/pht_front.sv =====
// ============================================================================
// Page hotness tracker front end
// Accepts operation transactions and classifies them into queue commands.
// ============================================================================
module pht_front (
  pht_in_if.sink                 in_i,
  input  pht_pkg::front_stall_t  stall_i,
  output logic                   push_o,
  output pht_pkg::cmd_t          cmd_o
);

  pht_pkg::op_e op;

  assign in_i.ready = !stall_i.queue_full && !stall_i.init_busy;
  assign push_o     = in_i.valid && in_i.ready;

  always_comb begin
    case (in_i.opcode)
      pht_pkg::OP_TRACK:   op = pht_pkg::OP_TRACK;
      pht_pkg::OP_SCAN:    op = pht_pkg::OP_SCAN;
      pht_pkg::OP_RELEASE: op = pht_pkg::OP_RELEASE;
      default:             op = pht_pkg::OP_NOP;
    endcase
  end

  // Only the fields that matter to each operation are passed on.
  always_comb begin
    cmd_o          = '0;
    cmd_o.op       = op;
    cmd_o.idx      = pht_pkg::IDX_W'(in_i.page_index);
    cmd_o.huge     = (op == pht_pkg::OP_TRACK) && in_i.huge_page;
    cmd_o.mapped   = (op == pht_pkg::OP_SCAN) && in_i.mapped;
    cmd_o.accessed = (op == pht_pkg::OP_SCAN) && in_i.accessed;
    cmd_o.dirty    = (op == pht_pkg::OP_SCAN) && in_i.dirty;
  end

endmodule

// ===== rtl/core/pht_fifo.sv =====
// ============================================================================
// Page hotness tracker command queue
// Short first-in first-out queue between the front end and the back end.
// ============================================================================
module pht_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pht_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          head_valid_o,
  output pht_pkg::cmd_t head_o
);

  pht_pkg::cmd_t                entries_q [pht_pkg::QUEUE_DEPTH];
  logic [pht_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [pht_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [pht_pkg::QCNT_W-1:0]   count_q, count_d;
  logic                         do_push;
  logic                         do_pop;

  assign full_o       = (count_q == pht_pkg::QCNT_W'(pht_pkg::QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == pht_pkg::QPTR_W'(pht_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == pht_pkg::QPTR_W'(pht_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/pht_back.sv =====
// ============================================================================
// Page hotness tracker back end
// Record store and read-modify-write sequencer that executes queued commands.
// ============================================================================
module pht_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [pht_pkg::THR_W-1:0]   thr_i,
  input  logic                        cmd_valid_i,
  input  pht_pkg::cmd_t               cmd_i,
  output logic                        cmd_ready_o,
  output logic                        init_busy_o,
  pht_out_if.source                   out_o
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_CALC  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [pht_pkg::IDX_W-1:0]     clr_cnt_q, clr_cnt_d;

  pht_pkg::rec_t                 mem [pht_pkg::PAGE_ENTRIES];
  pht_pkg::rec_t                 rdata_q;
  logic                          mem_we;
  logic [pht_pkg::IDX_W-1:0]     mem_waddr;
  pht_pkg::rec_t                 mem_wdata;
  logic                          mem_re;

  pht_pkg::cmd_t                 cmd_q;
  pht_pkg::rec_t                 new_rec;
  pht_pkg::rec_t                 new_q;
  logic [pht_pkg::DND_W-1:0]     dnd_dec;
  logic                          clr_a, clr_d, flush, blank;
  logic                          clr_a_q, clr_d_q, flush_q, blank_q, found_q;
  logic [pht_pkg::DEG_W-1:0]     prev_deg_q;
  logic [pht_pkg::DEG_W-1:0]     new_deg;
  logic                          load;

  logic                          out_valid_q, out_valid_d;
  logic                          o_found_q, o_changed_q, o_hot_q;
  logic                          o_clr_a_q, o_clr_d_q, o_flush_q, o_huge_q;
  logic [pht_pkg::DEGREE_W-1:0]  o_degree_q;
  logic [pht_pkg::QLEVEL_W-1:0]  o_level_q;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign init_busy_o = (state_q == ST_CLEAR);
  assign mem_re      = (state_q == ST_IDLE) && cmd_valid_i;

  // Record update for the command whose record was read last cycle.
  always_comb begin
    new_rec = rdata_q;
    clr_a   = 1'b0;
    clr_d   = 1'b0;
    flush   = 1'b0;
    dnd_dec = (rdata_q.dnd != '0) ? rdata_q.dnd - 1'b1 : '0;
    case (cmd_q.op)
      pht_pkg::OP_TRACK: begin
        new_rec       = '0;
        new_rec.valid = 1'b1;
        new_rec.huge  = cmd_q.huge;
      end
      pht_pkg::OP_RELEASE: begin
        new_rec.valid = 1'b0;
      end
      pht_pkg::OP_SCAN: begin
        if (rdata_q.valid) begin
          if (rdata_q.skip) begin
            new_rec.skip = 1'b0;
          end else begin
            new_rec.dnd = dnd_dec;
            if (cmd_q.mapped) begin
              new_rec.rd = {rdata_q.rd[pht_pkg::HISTORY_BITS-2:0], cmd_q.accessed};
              new_rec.wr = {rdata_q.wr[pht_pkg::HISTORY_BITS-2:0], cmd_q.dirty};
              if (dnd_dec == '0) begin
                if (cmd_q.accessed || cmd_q.dirty) begin
                  // Promotion: the page climbs a level unless already on top.
                  clr_a = cmd_q.accessed;
                  clr_d = cmd_q.dirty;
                  flush = 1'b1;
                  if (rdata_q.level < pht_pkg::LEVEL_W'(pht_pkg::QUEUE_LEVELS - 1)) begin
                    new_rec.level = rdata_q.level + 1'b1;
                    new_rec.dnd   = pht_pkg::dnd_for(new_rec.level);
                    new_rec.skip  = 1'b1;
                  end else begin
                    new_rec.dnd = pht_pkg::dnd_for(rdata_q.level);
                  end
                end else if (rdata_q.level != '0) begin
                  new_rec.level = rdata_q.level - 1'b1;
                  new_rec.dnd   = pht_pkg::dnd_for(new_rec.level);
                end else begin
                  new_rec.dnd = '0;
                end
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // A release, and any non-track command on an invalid record, reports
  // nothing but the found flag.
  assign blank = (cmd_q.op == pht_pkg::OP_RELEASE) ||
                 (!rdata_q.valid && (cmd_q.op != pht_pkg::OP_TRACK));

  assign new_deg = pht_pkg::deg_of(new_q.rd, new_q.wr);
  assign load    = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == pht_pkg::IDX_W'(pht_pkg::PAGE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cmd_q.idx;
    mem_wdata = new_rec;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (state_q == ST_CALC) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Record store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[cmd_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      cmd_q <= cmd_i;
    end
    if (state_q == ST_CALC) begin
      new_q      <= new_rec;
      found_q    <= rdata_q.valid;
      prev_deg_q <= rdata_q.valid ? pht_pkg::deg_of(rdata_q.rd, rdata_q.wr) : '0;
      clr_a_q    <= clr_a;
      clr_d_q    <= clr_d;
      flush_q    <= flush;
      blank_q    <= blank;
    end
    if (load) begin
      o_found_q   <= found_q;
      o_degree_q  <= blank_q ? '0 : pht_pkg::DEGREE_W'(new_deg);
      o_changed_q <= !blank_q && found_q && (new_deg != prev_deg_q);
      o_hot_q     <= !blank_q && (pht_pkg::DEGREE_W'(new_deg) >= thr_i);
      o_clr_a_q   <= !blank_q && clr_a_q;
      o_clr_d_q   <= !blank_q && clr_d_q;
      o_flush_q   <= !blank_q && flush_q;
      o_huge_q    <= !blank_q && new_q.huge;
      o_level_q   <= blank_q ? '0 : pht_pkg::QLEVEL_W'(new_q.level);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.found          = o_found_q;
  assign out_o.degree         = o_degree_q;
  assign out_o.degree_changed = o_changed_q;
  assign out_o.is_hot         = o_hot_q;
  assign out_o.clear_accessed = o_clr_a_q;
  assign out_o.clear_dirty    = o_clr_d_q;
  assign out_o.flush_range    = o_flush_q;
  assign out_o.is_huge        = o_huge_q;
  assign out_o.queue_level    = o_level_q;

endmodule

// ===== rtl/core/page_hotness_tracker.sv =====
// ============================================================================
// Page hotness tracker
// Per-page access history, queue level and hotness degree for tiered memory.
// ============================================================================
// The tracker holds one record for each of 1024 pages and takes three
// operations: track (re)creates a record, scan folds one accessed/dirty
// sample into it, and release drops it. Every accepted input transaction
// yields exactly one result transaction, in order, carrying the hotness
// degree min((2*reads + 3*writes)/5, 15), whether it changed, whether it
// reaches the active threshold, the clear and flush hints of a promotion,
// the huge-page mark and the queue level. After reset the block clears the
// record store, one record per cycle, and holds input ready low meanwhile;
// threshold writes are taken at any time. Then the back end reads the
// record in the cycle that it takes a command, updates and writes it back
// in its calculate state, and moves the result into the output register in
// its done state. That single read-modify-write sequencer over the record
// store takes a new command only after the last result has moved into the
// output register. A two-entry command queue lets the front end keep
// accepting while the back end works or the output is stalled, and the
// output register lets a new item start while a result still waits.
// ============================================================================
module page_hotness_tracker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pht_pkg::THR_W-1:0] cfg_wdata_i,
  pht_in_if.sink                    in_i,
  pht_out_if.source                 out_o
);

  // Active threshold register; a page at or above it counts as hot.
  logic [pht_pkg::THR_W-1:0] thr_q, thr_d;

  pht_pkg::front_stall_t stall;
  pht_pkg::cmd_t         push_cmd;
  pht_pkg::cmd_t         head_cmd;
  logic                  push;
  logic                  queue_full;
  logic                  head_valid;
  logic                  pop;
  logic                  init_busy;

  assign thr_d = cfg_we_i ? cfg_wdata_i : thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else begin
      thr_q <= thr_d;
    end
  end

  assign stall.queue_full = queue_full;
  assign stall.init_busy  = init_busy;

  // The front end decodes each accepted transaction into a command.
  pht_front u_front (
    .in_i    (in_i),
    .stall_i (stall),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  pht_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_cmd),
    .full_o       (queue_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_cmd)
  );

  // The back end owns the record store and drives the result channel.
  pht_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr_q),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_ready_o (pop),
    .init_busy_o (init_busy),
    .out_o       (out_o)
  );

endmodule

// ===== tb/pht_result_checker.sv =====
// ============================================================================
// Page hotness tracker result checker
// Watches the operation and result channels and keeps its own copy of every
// page record. It predicts the result of each accepted operation and compares
// the results that the block returns, in order, field by field.
// ============================================================================
module pht_result_checker
  import pht_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_wdata_i,
  pht_in_if                op_mon_i,
  pht_out_if               res_mon_i,
  output int               mismatches_o,
  output int               pending_o,
  output int               checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                    valid;
    logic                    skip;
    logic                    huge;
    logic [LEVEL_W-1:0]      level;
    logic [DND_W-1:0]        hold;
    logic [HISTORY_BITS-1:0] rd;
    logic [HISTORY_BITS-1:0] wr;
  } page_state_t;

  typedef struct packed {
    logic                found;
    logic [DEGREE_W-1:0] degree;
    logic                changed;
    logic                hot;
    logic                clr_acc;
    logic                clr_dirty;
    logic                flush;
    logic                huge;
    logic [QLEVEL_W-1:0] level;
  } page_result_t;

  page_state_t        pages [PAGE_ENTRIES];
  logic [THR_W-1:0]   hot_threshold;
  page_result_t       results_due [$];
  int                 failures;
  int                 compared;

  assign mismatches_o = failures;
  assign checked_o    = compared;

  function automatic logic [DEGREE_W-1:0] hotness_degree(logic [HISTORY_BITS-1:0] rd,
                                                         logic [HISTORY_BITS-1:0] wr);
    int weighted;
    weighted = (2 * $countones(rd) + 3 * $countones(wr)) / 5;
    if (weighted > DEGREE_BUCKETS - 1) begin
      weighted = DEGREE_BUCKETS - 1;
    end
    return DEGREE_W'(weighted);
  endfunction

  function automatic logic [DND_W-1:0] countdown_for_level(logic [LEVEL_W-1:0] lev);
    return (lev == '0) ? '0 : DND_W'(1) << (lev - 1);
  endfunction

  // Applies one operation to the local copy of the record store and returns
  // the result that the block has to produce for it.
  function automatic page_result_t predict_result(op_e op, logic [IDX_W-1:0] idx,
                                                  logic hp, logic mp, logic ac, logic dt);
    page_state_t         pg;
    page_result_t        res;
    logic [DEGREE_W-1:0] prior;
    logic [DEGREE_W-1:0] now;
    pg        = pages[idx];
    res       = '0;
    res.found = pg.valid;
    prior     = pg.valid ? hotness_degree(pg.rd, pg.wr) : '0;
    if (op == OP_RELEASE) begin
      pages[idx].valid = 1'b0;
      return res;
    end
    if (!pg.valid && op != OP_TRACK) begin
      return res;
    end
    if (op == OP_TRACK) begin
      pg          = '0;
      pg.valid    = 1'b1;
      pg.huge     = hp;
      res.changed = res.found && (prior != '0);
    end else if (op == OP_SCAN) begin
      if (pg.skip) begin
        pg.skip = 1'b0;
      end else begin
        if (pg.hold != '0) begin
          pg.hold = pg.hold - 1'b1;
        end
        if (mp) begin
          pg.rd = {pg.rd[HISTORY_BITS-2:0], ac};
          pg.wr = {pg.wr[HISTORY_BITS-2:0], dt};
          if (pg.hold == '0) begin
            if (ac || dt) begin
              // Promotion: one level up unless already at the top.
              res.clr_acc   = ac;
              res.clr_dirty = dt;
              res.flush     = 1'b1;
              if (pg.level < QUEUE_LEVELS - 1) begin
                pg.level = pg.level + 1'b1;
                pg.skip  = 1'b1;
              end
            end else if (pg.level != '0) begin
              pg.level = pg.level - 1'b1;
            end
            pg.hold = countdown_for_level(pg.level);
          end
        end
        res.changed = hotness_degree(pg.rd, pg.wr) != prior;
      end
    end
    pages[idx] = pg;
    now        = hotness_degree(pg.rd, pg.wr);
    res.degree = now;
    res.hot    = now >= hot_threshold;
    res.huge   = pg.huge;
    res.level  = QLEVEL_W'(pg.level);
    return res;
  endfunction

  function automatic string describe(page_result_t r);
    return $sformatf({"found=%0b degree=%0d changed=%0b hot=%0b clr_a=%0b clr_d=%0b ",
                      "flush=%0b huge=%0b level=%0d"},
                     r.found, r.degree, r.changed, r.hot, r.clr_acc, r.clr_dirty,
                     r.flush, r.huge, r.level);
  endfunction

  function automatic void log_failure(string what, string want, page_result_t got);
    failures++;
    if (failures <= 10) begin
      $display("[%0t] %s: expected %s, got %s", $time, what, want, describe(got));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t seen;
    page_result_t want;
    if (!rst_ni) begin
      foreach (pages[i]) begin
        pages[i] = '0;
      end
      hot_threshold = '0;
      results_due.delete();
      failures = 0;
      compared = 0;
    end else begin
      if (cfg_we_i) begin
        hot_threshold = cfg_wdata_i;
      end
      if (res_mon_i.valid && res_mon_i.ready) begin
        seen = {res_mon_i.found, res_mon_i.degree, res_mon_i.degree_changed, res_mon_i.is_hot,
                res_mon_i.clear_accessed, res_mon_i.clear_dirty, res_mon_i.flush_range,
                res_mon_i.is_huge, res_mon_i.queue_level};
        compared++;
        if (results_due.size() == 0) begin
          log_failure("result with no operation outstanding", "nothing", seen);
        end else begin
          want = results_due.pop_front();
          if (seen !== want) begin
            log_failure("result mismatch", describe(want), seen);
          end
        end
      end
      if (op_mon_i.valid && op_mon_i.ready) begin
        results_due.push_back(predict_result(op_e'(op_mon_i.opcode),
                                             IDX_W'(op_mon_i.page_index),
                                             op_mon_i.huge_page, op_mon_i.mapped,
                                             op_mon_i.accessed, op_mon_i.dirty));
      end
    end
    pending_o = results_due.size();
  end

endmodule

// ===== tb/testbench.sv =====
// ============================================================================
// Page hotness tracker testbench
// Drives track, scan and release operations into the page hotness tracker
// with random idle cycles on both channels and lets the result checker judge
// every returned result. A directed opening walks pages through promotion,
// the top level, demotion and release; random phases follow over a small
// working set of pages so that histories fill and degrees saturate.
// ============================================================================
module testbench;
  import pht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 225;
  localparam int POOL_PAGES    = 6;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [THR_W-1:0] cfg_wdata = '0;

  // Idle switches for the two channels; they are rerolled now and then so
  // that stretches with and without idle cycles both occur.
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;

  int mismatches;
  int pending;
  int checked;
  int ops_sent;
  int directed_ops;
  int settings_used;

  pht_in_if  op_if ();
  pht_out_if res_if ();

  page_hotness_tracker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (op_if),
    .out_o       (res_if)
  );

  pht_result_checker result_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .op_mon_i     (op_if),
    .res_mon_i    (res_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog. The slowest legal run, with the clearing pass after reset and
  // the longest gaps and stalls on every transaction, stays far below this.
  initial begin
    #2_000_000;
    $display("page_hotness_tracker regression: fail");
    $finish;
  end

  // Result side: for every result transaction the receiver draws a random stall
  // while rx_idle is set, then holds ready high until a transaction happens.
  initial begin
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = rx_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_if.ready = 1'b1;
      do @(posedge clk); while (!res_if.valid);
      @(negedge clk);
    end
  end

  // Presents one operation. It is entered and left at a falling edge. When no
  // gap is drawn, valid simply stays high and only the payload changes, so a
  // stream of back-to-back transactions hits the same page at full rate.
  task automatic send_op(op_e op, logic [PAGE_IDX_W-1:0] page, logic huge,
                         logic mapped, logic acc, logic dirty);
    int gap;
    gap = tx_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      op_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op_if.valid      = 1'b1;
    op_if.opcode     = op;
    op_if.page_index = page;
    op_if.huge_page  = huge;
    op_if.mapped     = mapped;
    op_if.accessed   = acc;
    op_if.dirty      = dirty;
    do @(posedge clk); while (!op_if.ready);
    @(negedge clk);
    ops_sent++;
  endtask

  // Stops sending and waits until every outstanding result has come back.
  // Each operation yields one result, so an empty queue of outstanding
  // results means the block is idle.
  task automatic drain();
    op_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [PAGE_IDX_W-1:0] pool [POOL_PAGES];
    logic [PAGE_IDX_W-1:0] page;
    int acc_pct;
    int dirty_pct;
    int pick;
    op_e op;

    op_if.valid      = 1'b0;
    op_if.opcode     = OP_TRACK;
    op_if.page_index = '0;
    op_if.huge_page  = 1'b0;
    op_if.mapped     = 1'b0;
    op_if.accessed   = 1'b0;
    op_if.dirty      = 1'b0;
    ops_sent         = 0;
    settings_used    = 0;

    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    write_threshold('0);

    // Directed opening, back to back on both sides so that repeated hits on
    // one page stress the read-modify-write sequencer. Operations on records
    // that do not exist yet come first, then page 0 is walked up to the top level.
    send_op(OP_SCAN,    10'd0,    1'b1, 1'b1, 1'b1, 1'b1);
    send_op(OP_RELEASE, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1);
    send_op(OP_NOP,     10'd5,    1'b1, 1'b1, 1'b1, 1'b1);
    send_op(OP_TRACK,   10'd0,    1'b1, 1'b0, 1'b0, 1'b0);
    send_op(OP_TRACK,   10'd1023, 1'b0, 1'b1, 1'b1, 1'b1);
    send_op(OP_NOP,     10'd0,    1'b0, 1'b0, 1'b0, 1'b0);
    // Promotion to level 1; the next scan only clears the skip flag.
    send_op(OP_SCAN,    10'd0,    1'b0, 1'b1, 1'b1, 1'b1);
    send_op(OP_SCAN,    10'd0,    1'b0, 1'b1, 1'b1, 1'b1);
    // Countdown runs out on a read-only sample: promotion to level 2.
    send_op(OP_SCAN,    10'd0,    1'b0, 1'b1, 1'b1, 1'b0);
    send_op(OP_SCAN,    10'd0,    1'b0, 1'b1, 1'b0, 1'b0);
    // An unmapped sample only lowers the countdown.
    send_op(OP_SCAN,    10'd0,    1'b1, 1'b0, 1'b1, 1'b1);
    // Write-only sample at countdown zero: promotion to the top level.
    send_op(OP_SCAN,    10'd0,    1'b0, 1'b1, 1'b0, 1'b1);
    send_op(OP_SCAN,    10'd0,    1'b0, 1'b1, 1'b1, 1'b1);
    // At the top level a promotion only reloads the countdown.
    repeat (4) send_op(OP_SCAN, 10'd0, 1'b0, 1'b1, 1'b1, 1'b1);
    // An idle sample with the countdown still running does not demote.
    send_op(OP_SCAN,    10'd0,    1'b0, 1'b1, 1'b0, 1'b0);
    // Tracking a live record resets it and reports the degree change.
    send_op(OP_TRACK,   10'd0,    1'b0, 1'b0, 1'b0, 1'b0);
    send_op(OP_RELEASE, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0);
    send_op(OP_RELEASE, 10'd0,    1'b0, 1'b0, 1'b0, 1'b0);
    // Demotion from level 1 to 0, then an idle sample at level 0 that cannot go lower.
    send_op(OP_TRACK,   10'd7,    1'b1, 1'b0, 1'b0, 1'b0);
    send_op(OP_SCAN,    10'd7,    1'b0, 1'b1, 1'b1, 1'b1);
    send_op(OP_SCAN,    10'd7,    1'b0, 1'b1, 1'b0, 1'b0);
    send_op(OP_SCAN,    10'd7,    1'b0, 1'b1, 1'b0, 1'b0);
    send_op(OP_SCAN,    10'd7,    1'b0, 1'b1, 1'b0, 1'b0);
    directed_ops = ops_sent;
    drain();

    // Random phases. Each phase picks a threshold, a small working set of
    // pages and its own access and dirty rates, tracks the working set and
    // then mostly scans it. A few operations hit arbitrary pages, most of
    // which hold no record.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        write_threshold(4'd15);
      end else if (ph == 1) begin
        write_threshold('0);
      end else begin
        write_threshold(THR_W'($urandom_range(1, 14)));
      end
      foreach (pool[k]) begin
        pool[k] = PAGE_IDX_W'($urandom_range(0, PAGE_ENTRIES - 1));
      end
      if (ph == 0) begin
        // Saturate histories on the boundary pages.
        pool[0]   = '0;
        pool[1]   = '1;
        acc_pct   = 95;
        dirty_pct = 90;
      end else begin
        acc_pct   = $urandom_range(5, 95);
        dirty_pct = $urandom_range(5, 95);
      end
      foreach (pool[k]) begin
        send_op(OP_TRACK, pool[k], 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          tx_idle = $urandom_range(0, 3) != 0;
          rx_idle = $urandom_range(0, 3) != 0;
        end
        // Halfway through, the sender holds off until all results are back.
        if (n == PHASE_ITEMS / 2) begin
          drain();
        end
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          op = OP_TRACK;
        end else if (pick < 9) begin
          op = OP_RELEASE;
        end else if (pick < 12) begin
          op = OP_NOP;
        end else begin
          op = OP_SCAN;
        end
        if ($urandom_range(0, 9) == 0) begin
          page = PAGE_IDX_W'($urandom_range(0, PAGE_ENTRIES - 1));
        end else begin
          page = pool[$urandom_range(0, POOL_PAGES - 1)];
        end
        send_op(op, page, 1'($urandom_range(0, 1)), $urandom_range(0, 9) != 0,
                $urandom_range(0, 99) < acc_pct, $urandom_range(0, 99) < dirty_pct);
      end
      drain();
    end

    repeat (10) @(negedge clk);
    $display("Ran %0d operations (%0d directed) under %0d threshold settings; %0d results compared.",
             ops_sent, directed_ops, settings_used, checked);
    if (mismatches == 0 && pending == 0) begin
      $display("page_hotness_tracker regression: pass");
    end else begin
      $display("page_hotness_tracker regression: fail");
    end
    $finish;
  end

endmodule
